@@ hdl/rrtsm_pkg.sv @@
// Shared types and constants of the round-robin thread state manager.
package rrtsm_pkg;

    typedef enum logic [2:0] {
        K_ADD    = 3'd0,
        K_YIELD  = 3'd1,
        K_SWITCH = 3'd2,
        K_JOIN   = 3'd3,
        K_EXIT   = 3'd4,
        K_WAKE   = 3'd5,
        K_KILL   = 3'd6,
        K_FORGET = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        TS_ABSENT  = 3'd0,
        TS_READY   = 3'd1,
        TS_RUNNING = 3'd2,
        TS_SUSP    = 3'd3,
        TS_FIN     = 3'd4
    } thr_state_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EXITED  = 2'd2;

    localparam int MAX_DLV = 16;
    localparam int DW      = 4;
    localparam int DCW     = 5;

    typedef struct packed {
        logic push;
        logic start;
        logic drop;
    } list_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic full;
    } list_stat_t;

endpackage

@@ hdl/rrtsm_req_if.sv @@
// Request channel of the thread state manager.
interface rrtsm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  target_thread;
    logic        target_valid;
    logic        want_result;
    logic [31:0] value;

    modport source (output valid, kind, target_thread, target_valid, want_result, value,
                    input ready);
    modport sink (input valid, kind, target_thread, target_valid, want_result, value,
                  output ready);
endinterface

@@ hdl/rrtsm_rsp_if.sv @@
// Result channel of the thread state manager.
interface rrtsm_rsp_if;
    logic        valid;
    logic        ready;
    logic        item_type;
    logic [1:0]  status;
    logic        running_valid;
    logic [3:0]  running_thread;
    logic        target_finished;
    logic [3:0]  delivered_thread;
    logic [31:0] delivered_value;
    logic        last;

    modport source (output valid, item_type, status, running_valid, running_thread,
                    target_finished, delivered_thread, delivered_value, last,
                    input ready);
    modport sink (input valid, item_type, status, running_valid, running_thread,
                  target_finished, delivered_thread, delivered_value, last,
                  output ready);
endinterface

@@ hdl/rrtsm_list.sv @@
// Ordered thread list with append and a compacting walk that drops entries.
module rrtsm_list #(
    parameter int MAX_THREADS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rrtsm_pkg::list_ctrl_t               ctrl,
    input  logic [$clog2(MAX_THREADS)-1:0]      push_id,
    output rrtsm_pkg::list_stat_t               stat,
    output logic [$clog2(MAX_THREADS)-1:0]      head,
    output logic [$clog2(MAX_THREADS)-1:0]      cur,
    output logic [$clog2(MAX_THREADS+1)-1:0]    count
);
    import rrtsm_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    logic [IW-1:0] mem [MAX_THREADS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] rd_reg;
    logic [CW-1:0] wr_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          full;
    logic          walk_end;

    assign full     = (count_reg == CW'(MAX_THREADS));
    assign walk_end = (rd_reg == count_reg);
    assign cur      = mem[rd_reg[IW-1:0]];
    assign head     = mem[0];
    assign count    = count_reg;
    assign stat     = '{busy: busy_reg, done: done_reg, full: full};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                rd_reg   <= '0;
                wr_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (walk_end)
                begin
                    count_reg <= wr_reg;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    rd_reg <= rd_reg + 1'b1;
                    if (!ctrl.drop)
                    begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                end
            end
            else if (ctrl.push && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Kept entries slide down to the write position during a walk.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !ctrl.start && !walk_end && !ctrl.drop)
        begin
            mem[wr_reg[IW-1:0]] <= cur;
        end
        else if (!busy_reg && !ctrl.start && ctrl.push && !full)
        begin
            mem[count_reg[IW-1:0]] <= push_id;
        end
    end

endmodule

@@ hdl/round_robin_thread_state_manager_unit.sv @@
// Top level of the round-robin thread state manager.
//
// One request beat on req names an operation and a thread. The block answers
// on rsp with zero or more value deliveries (item_type 1), one per released
// waiter that asked for the result, followed by a status reply (item_type 0)
// marked with last. Every beat carries the running thread and the finished
// flag of the named thread as they stand after the whole request.
// Requests are handled one at a time: req.ready is high only while idle.
// A request is decoded, then runs the list walks it needs, then emits its
// result beats. A walk over the ready list or the suspend list steps through
// its entries one at a time; the walks through the ordered lists set the
// worst-case time of a request, which grows with MAX_THREADS.
// Reset empties both lists, marks all threads absent and stops the running
// thread; no clearing pass is needed. When the receiver stalls, the
// finished beat waits in the output register and the sequencer waits with it.
// The next request can be taken while the final reply still waits.
module round_robin_thread_state_manager_unit #(
    parameter int MAX_THREADS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    rrtsm_req_if.sink   req,
    rrtsm_rsp_if.source rsp
);
    import rrtsm_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_RMW    = 7'b0000100,
        S_FIX    = 7'b0001000,
        S_REL    = 7'b0010000,
        S_SCHED  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    kind_t       kind_reg, kind_next;
    logic [3:0]  t_reg, t_next;
    logic        tv_reg, tv_next;
    logic        want_reg, want_next;
    logic [31:0] val_reg, val_next;
    logic        run_valid_reg, run_valid_next;
    logic [IW-1:0] run_id_reg, run_id_next;
    logic [1:0]  st_reg, st_next;
    logic [3:0]  rdth_reg, rdth_next;
    logic [31:0] rdval_reg, rdval_next;
    logic [IW-1:0] fin_id_reg, fin_id_next;
    logic [31:0] fin_val_reg, fin_val_next;
    logic        sched_pend_reg, sched_pend_next;
    logic        popping_reg, popping_next;
    logic        walk_susp_reg, walk_susp_next;
    logic [IW-1:0] walk_id_reg, walk_id_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [DCW-1:0] emit_k_reg, emit_k_next;
    logic [IW-1:0] dlv_reg [MAX_DLV];

    logic        out_valid_reg, out_valid_next;
    logic        out_type_reg, out_type_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic        out_rv_reg, out_rv_next;
    logic [3:0]  out_rt_reg, out_rt_next;
    logic        out_tf_reg, out_tf_next;
    logic [3:0]  out_dth_reg, out_dth_next;
    logic [31:0] out_dval_reg, out_dval_next;
    logic        out_last_reg, out_last_next;

    thr_state_t  thr_st_reg [MAX_THREADS];
    logic        aw_valid_reg [MAX_THREADS];
    logic        aw_want_reg [MAX_THREADS];
    logic [3:0]  aw_id_reg [MAX_THREADS];
    logic [31:0] fval_reg [MAX_THREADS];

    // Two status write ports, one await write port, one value write port.
    logic        wa_en, wb_en, aw_we, fv_we, dlv_we;
    logic [IW-1:0] wa_idx, wb_idx, aw_idx, fv_idx;
    thr_state_t  wa_val, wb_val;
    logic [31:0] fv_val;

    list_ctrl_t  rdy_ctrl, susp_ctrl;
    list_stat_t  rdy_stat, susp_stat;
    logic [IW-1:0] rdy_push_id, susp_push_id;
    logic [IW-1:0] rdy_head, rdy_cur, susp_head, susp_cur;
    logic [CW-1:0] rdy_count, susp_count;

    logic        tok;
    logic [IW-1:0] tidx;
    thr_state_t  ts;
    logic        rel_match;
    logic        out_free;

    rrtsm_list #(.MAX_THREADS(MAX_THREADS)) u_ready (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rdy_ctrl),
        .push_id (rdy_push_id),
        .stat    (rdy_stat),
        .head    (rdy_head),
        .cur     (rdy_cur),
        .count   (rdy_count)
    );

    rrtsm_list #(.MAX_THREADS(MAX_THREADS)) u_susp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (susp_ctrl),
        .push_id (susp_push_id),
        .stat    (susp_stat),
        .head    (susp_head),
        .cur     (susp_cur),
        .count   (susp_count)
    );

    assign tok  = (32'(t_reg) < MAX_THREADS);
    assign tidx = IW'(t_reg);
    assign ts   = tok ? thr_st_reg[tidx] : TS_ABSENT;

    // A suspended entry is released when it awaits the finishing thread.
    assign rel_match = susp_stat.busy && (susp_count != '0) &&
                       (thr_st_reg[susp_cur] == TS_SUSP) && aw_valid_reg[susp_cur] &&
                       (32'(aw_id_reg[susp_cur]) == 32'(fin_id_reg));

    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid            = out_valid_reg;
    assign rsp.item_type        = out_type_reg;
    assign rsp.status           = out_st_reg;
    assign rsp.running_valid    = out_rv_reg;
    assign rsp.running_thread   = out_rt_reg;
    assign rsp.target_finished  = out_tf_reg;
    assign rsp.delivered_thread = out_dth_reg;
    assign rsp.delivered_value  = out_dval_reg;
    assign rsp.last             = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        t_next          = t_reg;
        tv_next         = tv_reg;
        want_next       = want_reg;
        val_next        = val_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        st_next         = st_reg;
        rdth_next       = rdth_reg;
        rdval_next      = rdval_reg;
        fin_id_next     = fin_id_reg;
        fin_val_next    = fin_val_reg;
        sched_pend_next = sched_pend_reg;
        popping_next    = popping_reg;
        walk_susp_next  = walk_susp_reg;
        walk_id_next    = walk_id_reg;
        dcnt_next       = dcnt_reg;
        emit_k_next     = emit_k_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_type_next   = out_type_reg;
        out_st_next     = out_st_reg;
        out_rv_next     = out_rv_reg;
        out_rt_next     = out_rt_reg;
        out_tf_next     = out_tf_reg;
        out_dth_next    = out_dth_reg;
        out_dval_next   = out_dval_reg;
        out_last_next   = out_last_reg;
        wa_en  = 1'b0;
        wa_idx = run_id_reg;
        wa_val = TS_READY;
        wb_en  = 1'b0;
        wb_idx = tidx;
        wb_val = TS_RUNNING;
        aw_we  = 1'b0;
        aw_idx = run_id_reg;
        fv_we  = 1'b0;
        fv_idx = run_id_reg;
        fv_val = val_reg;
        dlv_we = 1'b0;
        rdy_ctrl     = '0;
        susp_ctrl    = '0;
        rdy_push_id  = run_id_reg;
        susp_push_id = run_id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next       = kind_t'(req.kind);
                    t_next          = req.target_thread;
                    tv_next         = req.target_valid;
                    want_next       = req.want_result;
                    val_next        = req.value;
                    st_next         = ST_OK;
                    rdth_next       = '0;
                    rdval_next      = '0;
                    dcnt_next       = '0;
                    emit_k_next     = '0;
                    sched_pend_next = 1'b0;
                    popping_next    = 1'b0;
                    state_next      = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_EMIT;
                unique case (kind_reg)
                    K_ADD:
                    begin
                        if (!tok)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (ts == TS_ABSENT)
                        begin
                            rdy_ctrl.push = 1'b1;
                            rdy_push_id   = tidx;
                            wa_en  = !rdy_stat.full;
                            wa_idx = tidx;
                            wa_val = TS_READY;
                        end
                        else
                        begin
                            st_next = (ts == TS_FIN) ? ST_EXITED : ST_INVALID;
                        end
                    end
                    K_YIELD:
                    begin
                        if (run_valid_reg)
                        begin
                            rdy_ctrl.push  = 1'b1;
                            wa_en          = !rdy_stat.full;
                            run_valid_next = 1'b0;
                        end
                        state_next = S_SCHED;
                    end
                    K_SWITCH:
                    begin
                        if (!tok)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (run_valid_reg && run_id_reg == tidx)
                        begin
                            st_next = ST_OK;
                        end
                        else if (ts == TS_READY)
                        begin
                            rdy_ctrl.start = 1'b1;
                            walk_susp_next = 1'b0;
                            walk_id_next   = tidx;
                            state_next     = S_RMW;
                        end
                        else
                        begin
                            st_next = ST_INVALID;
                        end
                    end
                    K_JOIN:
                    begin
                        if (tv_reg && tok && ts == TS_FIN)
                        begin
                            if (want_reg)
                            begin
                                rdth_next  = run_valid_reg ? 4'(run_id_reg) : 4'd0;
                                rdval_next = fval_reg[tidx];
                            end
                        end
                        else if (tv_reg && !tok)
                        begin
                            st_next = ST_INVALID;
                        end
                        else
                        begin
                            if (run_valid_reg)
                            begin
                                wa_en  = 1'b1;
                                wa_val = TS_SUSP;
                                aw_we  = 1'b1;
                                susp_ctrl.push = 1'b1;
                                run_valid_next = 1'b0;
                            end
                            state_next = S_SCHED;
                        end
                    end
                    K_EXIT:
                    begin
                        if (run_valid_reg)
                        begin
                            run_valid_next  = 1'b0;
                            wa_en           = 1'b1;
                            wa_val          = TS_FIN;
                            fv_we           = 1'b1;
                            fin_id_next     = run_id_reg;
                            fin_val_next    = val_reg;
                            susp_ctrl.start = 1'b1;
                            sched_pend_next = 1'b1;
                            state_next      = S_REL;
                        end
                        else
                        begin
                            state_next = S_SCHED;
                        end
                    end
                    K_WAKE:
                    begin
                        if (ts == TS_ABSENT)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (ts == TS_FIN)
                        begin
                            st_next = ST_EXITED;
                        end
                        else if (ts == TS_SUSP)
                        begin
                            susp_ctrl.start = 1'b1;
                            walk_susp_next  = 1'b1;
                            walk_id_next    = tidx;
                            state_next      = S_RMW;
                        end
                    end
                    K_KILL:
                    begin
                        if (ts == TS_ABSENT)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (ts == TS_FIN)
                        begin
                            st_next = ST_EXITED;
                        end
                        else if (ts == TS_RUNNING)
                        begin
                            run_valid_next  = 1'b0;
                            wa_en           = 1'b1;
                            wa_idx          = tidx;
                            wa_val          = TS_FIN;
                            fv_we           = 1'b1;
                            fv_idx          = tidx;
                            fv_val          = '0;
                            fin_id_next     = tidx;
                            fin_val_next    = '0;
                            susp_ctrl.start = 1'b1;
                            sched_pend_next = 1'b1;
                            state_next      = S_REL;
                        end
                        else
                        begin
                            rdy_ctrl.start  = (ts == TS_READY);
                            susp_ctrl.start = (ts != TS_READY);
                            walk_susp_next  = (ts != TS_READY);
                            walk_id_next    = tidx;
                            state_next      = S_RMW;
                        end
                    end
                    K_FORGET:
                    begin
                        if (ts == TS_ABSENT || ts == TS_RUNNING)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (ts == TS_FIN)
                        begin
                            wa_en  = 1'b1;
                            wa_idx = tidx;
                            wa_val = TS_ABSENT;
                        end
                        else
                        begin
                            rdy_ctrl.start  = (ts == TS_READY);
                            susp_ctrl.start = (ts != TS_READY);
                            walk_susp_next  = (ts != TS_READY);
                            walk_id_next    = tidx;
                            state_next      = S_RMW;
                        end
                    end
                    default:
                    begin
                        st_next = ST_INVALID;
                    end
                endcase
            end

            S_RMW:
            begin
                rdy_ctrl.drop  = !walk_susp_reg && (rdy_cur == walk_id_reg);
                susp_ctrl.drop = walk_susp_reg && (susp_cur == walk_id_reg);
                if ((walk_susp_reg && susp_stat.done) || (!walk_susp_reg && rdy_stat.done))
                begin
                    state_next = popping_reg ? S_EMIT : S_FIX;
                end
            end

            S_FIX:
            begin
                state_next = S_EMIT;
                priority case (kind_reg)
                    K_SWITCH:
                    begin
                        if (run_valid_reg)
                        begin
                            rdy_ctrl.push = 1'b1;
                            wa_en         = !rdy_stat.full;
                        end
                        wb_en          = 1'b1;
                        run_valid_next = 1'b1;
                        run_id_next    = tidx;
                    end
                    K_WAKE:
                    begin
                        rdy_ctrl.push = 1'b1;
                        rdy_push_id   = tidx;
                        wa_en         = !rdy_stat.full;
                        wa_idx        = tidx;
                    end
                    K_KILL:
                    begin
                        wa_en           = 1'b1;
                        wa_idx          = tidx;
                        wa_val          = TS_FIN;
                        fv_we           = 1'b1;
                        fv_idx          = tidx;
                        fv_val          = '0;
                        fin_id_next     = tidx;
                        fin_val_next    = '0;
                        susp_ctrl.start = 1'b1;
                        state_next      = S_REL;
                    end
                    K_FORGET:
                    begin
                        wa_en  = 1'b1;
                        wa_idx = tidx;
                        wa_val = TS_ABSENT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_REL:
            begin
                susp_ctrl.drop = rel_match;
                if (rel_match)
                begin
                    rdy_ctrl.push = 1'b1;
                    rdy_push_id   = susp_cur;
                    wa_en         = !rdy_stat.full;
                    wa_idx        = susp_cur;
                    if (aw_want_reg[susp_cur] && dcnt_reg < DCW'(MAX_DLV))
                    begin
                        dlv_we    = 1'b1;
                        dcnt_next = dcnt_reg + 1'b1;
                    end
                end
                if (susp_stat.done)
                begin
                    state_next = sched_pend_reg ? S_SCHED : S_EMIT;
                end
            end

            S_SCHED:
            begin
                if (rdy_count == '0)
                begin
                    run_valid_next = 1'b0;
                    run_id_next    = '0;
                    st_next        = ST_INVALID;
                    state_next     = S_EMIT;
                end
                else
                begin
                    wa_en          = 1'b1;
                    wa_idx         = rdy_head;
                    wa_val         = TS_RUNNING;
                    run_valid_next = 1'b1;
                    run_id_next    = rdy_head;
                    rdy_ctrl.start = 1'b1;
                    walk_susp_next = 1'b0;
                    walk_id_next   = rdy_head;
                    popping_next   = 1'b1;
                    state_next     = S_RMW;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rv_next    = run_valid_reg;
                    out_rt_next    = run_valid_reg ? 4'(run_id_reg) : 4'd0;
                    out_tf_next    = tok && (thr_st_reg[tidx] == TS_FIN);
                    if (emit_k_reg < dcnt_reg)
                    begin
                        out_type_next = 1'b1;
                        out_st_next   = ST_OK;
                        out_dth_next  = 4'(dlv_reg[emit_k_reg[DW-1:0]]);
                        out_dval_next = fin_val_reg;
                        out_last_next = 1'b0;
                        emit_k_next   = emit_k_reg + 1'b1;
                    end
                    else
                    begin
                        out_type_next = 1'b0;
                        out_st_next   = st_reg;
                        out_dth_next  = rdth_reg;
                        out_dval_next = rdval_reg;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            run_valid_reg  <= 1'b0;
            run_id_reg     <= '0;
            out_valid_reg  <= 1'b0;
            dcnt_reg       <= '0;
            emit_k_reg     <= '0;
            sched_pend_reg <= 1'b0;
            popping_reg    <= 1'b0;
            walk_susp_reg  <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                thr_st_reg[i] <= TS_ABSENT;
            end
        end
        else
        begin
            state_reg      <= state_next;
            run_valid_reg  <= run_valid_next;
            run_id_reg     <= run_id_next;
            out_valid_reg  <= out_valid_next;
            dcnt_reg       <= dcnt_next;
            emit_k_reg     <= emit_k_next;
            sched_pend_reg <= sched_pend_next;
            popping_reg    <= popping_next;
            walk_susp_reg  <= walk_susp_next;
            if (wa_en)
            begin
                thr_st_reg[wa_idx] <= wa_val;
            end
            if (wb_en)
            begin
                thr_st_reg[wb_idx] <= wb_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        t_reg        <= t_next;
        tv_reg       <= tv_next;
        want_reg     <= want_next;
        val_reg      <= val_next;
        st_reg       <= st_next;
        rdth_reg     <= rdth_next;
        rdval_reg    <= rdval_next;
        fin_id_reg   <= fin_id_next;
        fin_val_reg  <= fin_val_next;
        walk_id_reg  <= walk_id_next;
        out_type_reg <= out_type_next;
        out_st_reg   <= out_st_next;
        out_rv_reg   <= out_rv_next;
        out_rt_reg   <= out_rt_next;
        out_tf_reg   <= out_tf_next;
        out_dth_reg  <= out_dth_next;
        out_dval_reg <= out_dval_next;
        out_last_reg <= out_last_next;
        if (aw_we)
        begin
            aw_valid_reg[aw_idx] <= tv_reg;
            aw_want_reg[aw_idx]  <= want_reg;
            aw_id_reg[aw_idx]    <= t_reg;
        end
        if (fv_we)
        begin
            fval_reg[fv_idx] <= fv_val;
        end
        if (dlv_we)
        begin
            dlv_reg[dcnt_reg[DW-1:0]] <= susp_cur;
        end
    end

endmodule
